// ===== sv/aef_pkg.sv =====
// ----------------------------------------------------------------------------
// aef_pkg
// Shared constants and types of the alpha emboss filter.
// ----------------------------------------------------------------------------
package aef_pkg;

  localparam int MAX_WIDTH  = 1024;

  localparam int PIX_W      = 8;
  localparam int RGBA_W     = 4 * PIX_W;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int IMG_W_FLD  = 11;
  localparam int HGT_W      = 13;
  // Row position runs up to the programmed height plus one, the last of two drain rows
  localparam int ROW_W      = HGT_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  // Five-point alpha sum, gradient and blend widths
  localparam int SUM_W      = 12;
  localparam int GRAD_W     = SUM_W + 2;
  localparam int ABS_W      = SUM_W + 1;
  localparam int MAG_W      = 16;
  localparam int INV_W      = MAG_W + 1;
  localparam int PROD_W     = PIX_W + INV_W;
  localparam int CENTRE_WEIGHT = 12;

  // |g| * 4096 / 765 == (|g| * RECIP_MUL) >> RECIP_SHIFT, exact for |g| < 2^13
  localparam int RECIP_W     = 26;
  localparam int RECIP_PW    = ABS_W + RECIP_W;
  localparam int RECIP_SHIFT = 23;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 26'd44914691;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic row_ge1;
    logic live;
    logic row_ge2;
    logic row_ge3;
    logic has_left;
    logic has_right;
    logic fwd_right;
    logic emit;
    logic last;
  } flags_t;

endpackage

// ===== sv/aef_if.sv =====
// ----------------------------------------------------------------------------
// aef_in_if / aef_out_if
// Valid/ready pixel channels into and out of the emboss filter.
// ----------------------------------------------------------------------------
interface aef_in_if import aef_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;
  logic [PIX_W-1:0] alpha_in;

  modport source (output valid, command, red_in, green_in, blue_in, alpha_in,
                  input ready);
  modport sink (input valid, command, red_in, green_in, blue_in, alpha_in,
                output ready);
endinterface

interface aef_out_if import aef_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;
  logic [PIX_W-1:0] alpha_out;
  logic             frame_end;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, frame_end,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, frame_end,
                output ready);
endinterface

// ===== sv/aef_ram.sv =====
// ----------------------------------------------------------------------------
// aef_ram
// Generic RAM: one write port, two registered read ports, read-first.
// ----------------------------------------------------------------------------
module aef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem_r[rd_addr_a];
      rd_b_r <= mem_r[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// ===== sv/alpha_emboss_filter_core.sv =====
// ----------------------------------------------------------------------------
// alpha_emboss_filter_core
// Streaming 3x3 emboss of an RGBA raster, relief shaped by smoothed alpha.
// ----------------------------------------------------------------------------
// The block takes one pixel or flush transfer per clock and gives at most one
// embossed pixel per transfer; only output stalls slow the stream below one
// item per cycle, since every line store is read and written once per item
// and the rest is a six-stage pipeline (RAM read, five-point sum, gradient,
// reciprocal multiply, per-channel blend multiply, output register). The
// result for pixel (x, y) is released by the transfer at (x, y+2), so an
// image is drained by 2*image_width flush transfers after its last pixel;
// frame_end marks the last pixel, after which the stream position returns to
// the start. A flush sent before any item of the image is dropped without a
// result. Program image_width and image_height only while the block is idle;
// either write restarts the stream position. Line stores need no clearing
// after reset.
// ----------------------------------------------------------------------------
module alpha_emboss_filter_core import aef_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  aef_in_if.sink                in_chan,
  aef_out_if.source             out_chan
);

  // --------------------------------------------------------------------------
  // Configuration and stream position
  // --------------------------------------------------------------------------
  logic [WID_W-1:0] eff_w_r;
  logic [HGT_W-1:0] eff_h_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic [IMG_W_FLD-1:0] w_raw;
  logic [HGT_W-1:0]     h_raw;
  logic [WID_W-1:0]     w_clamped;
  logic [HGT_W-1:0]     h_clamped;

  assign w_raw = cfg_data[IMG_W_FLD-1:0];
  assign h_raw = cfg_data[HGT_W-1:0];

  always_comb begin
    if (w_raw == '0) begin
      w_clamped = WID_W'(1);
    end else if (CFG_DATA_W'(w_raw) > CFG_DATA_W'(MAX_WIDTH)) begin
      w_clamped = WID_W'(MAX_WIDTH);
    end else begin
      w_clamped = WID_W'(w_raw);
    end
    h_clamped = (h_raw == '0) ? HGT_W'(1) : h_raw;
  end

  // --------------------------------------------------------------------------
  // Stage handshake: each stage loads when empty or when it drains forward
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic ld1, ld2, ld3, ld4, ld5, ld6;
  logic accept, adv1;

  assign ld6 = !v6_r || out_chan.ready;
  assign ld5 = !v5_r || ld6;
  assign ld4 = !v4_r || ld5;
  assign ld3 = !v3_r || ld4;
  assign ld2 = !v2_r || ld3;
  assign ld1 = !v1_r || ld2;

  assign in_chan.ready = ld1;
  assign accept        = in_chan.valid && ld1;
  assign adv1          = v1_r && ld2;

  // --------------------------------------------------------------------------
  // Accept stage: classify the transfer against the stream position
  // --------------------------------------------------------------------------
  logic       is_flush, ign, pix_ok, col_last, row_final;
  logic [PIX_W-1:0]  a_in;
  logic [RGBA_W-1:0] rgba;
  flags_t     flags0;

  assign is_flush  = (in_chan.command == CMD_FLUSH);
  assign ign       = is_flush && (col_r == '0) && (row_r == '0);
  assign pix_ok    = (in_chan.command == CMD_PIXEL) && (row_r < ROW_W'(eff_h_r));
  assign col_last  = (WID_W'(col_r) + WID_W'(1)) == eff_w_r;
  assign row_final = row_r == (ROW_W'(eff_h_r) + ROW_W'(1));

  // Pixels beyond the image and flushes carry zero
  assign a_in = pix_ok ? in_chan.alpha_in : '0;
  assign rgba = pix_ok ? {in_chan.alpha_in, in_chan.blue_in, in_chan.green_in,
                          in_chan.red_in} : '0;

  always_comb begin
    flags0.row_ge1   = row_r >= ROW_W'(1);
    flags0.live      = (row_r >= ROW_W'(1)) && (row_r <= ROW_W'(eff_h_r));
    flags0.row_ge2   = row_r >= ROW_W'(2);
    flags0.row_ge3   = row_r >= ROW_W'(3);
    flags0.has_left  = col_r != '0;
    flags0.has_right = !col_last;
    // On two-column images the right neighbour above was written by the
    // transfer just before: take it from the bypass register.
    flags0.fwd_right = (eff_w_r == WID_W'(2)) && (col_r == '0);
    flags0.emit      = row_r >= ROW_W'(2);
    flags0.last      = row_final && col_last;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept && !ign) begin
      if (flags0.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_last) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= WID_W'(1);
      eff_h_r <= HGT_W'(1);
      col_r   <= '0;
      row_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          eff_w_r <= w_clamped;
        end
        REG_IMAGE_HEIGHT: begin
          eff_h_r <= h_clamped;
        end
        default: begin
        end
      endcase
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Line stores. Row parity selects the half (or bank) that holds the
  // current row; the other holds the row above.
  // --------------------------------------------------------------------------
  logic              par0;
  logic              wr_line;
  logic [COL_W-1:0]  col_p1, col_m1;
  logic [PIX_W-1:0]  alpha_c, alpha_rt;
  logic [RGBA_W-1:0] colour_old;

  assign par0    = row_r[0];
  assign wr_line = accept && !ign;
  assign col_p1  = col_r + COL_W'(1);
  assign col_m1  = col_r - COL_W'(1);

  // Alpha of the row above: centre and right neighbour
  aef_ram #(.WIDTH(PIX_W), .DEPTH(2 * MAX_WIDTH)) u_alpha_rows (
    .clk       (clk),
    .we        (wr_line),
    .wr_addr   ({par0, col_r}),
    .wr_data   (a_in),
    .rd_en     (accept),
    .rd_addr_a ({!par0, col_r}),
    .rd_addr_b ({!par0, col_p1}),
    .rd_data_a (alpha_c),
    .rd_data_b (alpha_rt)
  );

  // Colour two rows back; its alpha byte is also the alpha two rows back
  aef_ram #(.WIDTH(RGBA_W), .DEPTH(2 * MAX_WIDTH)) u_colour_delay (
    .clk       (clk),
    .we        (wr_line),
    .wr_addr   ({par0, col_r}),
    .wr_data   (rgba),
    .rd_en     (accept),
    .rd_addr_a ({par0, col_r}),
    .rd_addr_b ({par0, col_r}),
    .rd_data_a (colour_old),
    .rd_data_b ()
  );

  // Smoothed sums, one bank per row parity
  logic [SUM_W-1:0] sm_a   [2];
  logic [SUM_W-1:0] sm_b   [2];
  logic [SUM_W-1:0] s_new;
  logic [COL_W-1:0] c1_r;
  logic             par1_r;
  flags_t           f1_r;

  for (genvar b = 0; b < 2; b++) begin : g_sm_bank
    logic [COL_W-1:0] addr_a;
    assign addr_a = (par0 != 1'(b)) ? col_r : col_m1;
    aef_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WIDTH)) u_smoothed_rows (
      .clk       (clk),
      .we        (adv1 && f1_r.row_ge1 && (par1_r != 1'(b))),
      .wr_addr   (c1_r),
      .wr_data   (s_new),
      .rd_en     (accept),
      .rd_addr_a (addr_a),
      .rd_addr_b (col_p1),
      .rd_data_a (sm_a[b]),
      .rd_data_b (sm_b[b])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 1: five-point alpha sum for the pixel one row up
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] a1_r;
  logic [PIX_W-1:0] alpha_left_r;
  logic [SUM_W-1:0] last_snew_r;
  logic [SUM_W-1:0] s_old1, s_left1, s_right1;

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_r   <= flags0;
      a1_r   <= a_in;
      c1_r   <= col_r;
      par1_r <= par0;
    end
    // The centre above of this pixel is the left above of the next one
    if (adv1) begin
      alpha_left_r <= alpha_c;
      last_snew_r  <= s_new;
    end
  end

  always_comb begin
    s_new = '0;
    if (f1_r.live) begin
      s_new = SUM_W'(alpha_c) * SUM_W'(CENTRE_WEIGHT) + SUM_W'(a1_r);
      if (f1_r.row_ge2) begin
        s_new = s_new + SUM_W'(colour_old[RGBA_W-1 -: PIX_W]);
      end
      if (f1_r.has_left) begin
        s_new = s_new + SUM_W'(alpha_left_r);
      end
      if (f1_r.has_right) begin
        s_new = s_new + SUM_W'(alpha_rt);
      end
    end
  end

  assign s_old1   = par1_r ? sm_a[0] : sm_a[1];
  assign s_left1  = par1_r ? sm_a[1] : sm_a[0];
  assign s_right1 = f1_r.fwd_right ? last_snew_r : (par1_r ? sm_b[1] : sm_b[0]);

  // --------------------------------------------------------------------------
  // Stage 2: gradient below - above + right - left
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0]  snew2_r, sold2_r, right2_r, left2_r;
  logic [RGBA_W-1:0] col2_r;
  logic              end2_r;
  logic signed [GRAD_W-1:0] grad2;
  logic [ABS_W-1:0]  abs2;

  always_ff @(posedge clk) begin
    if (ld2) begin
      snew2_r  <= s_new;
      sold2_r  <= f1_r.row_ge3 ? s_old1 : '0;
      right2_r <= f1_r.has_right ? s_right1 : '0;
      left2_r  <= f1_r.has_left ? s_left1 : '0;
      col2_r   <= colour_old;
      end2_r   <= f1_r.last;
    end
  end

  assign grad2 = $signed(GRAD_W'(snew2_r)) + $signed(GRAD_W'(right2_r))
               - $signed(GRAD_W'(sold2_r)) - $signed(GRAD_W'(left2_r));
  assign abs2  = grad2[GRAD_W-1] ? ABS_W'(-grad2) : ABS_W'(grad2);

  // --------------------------------------------------------------------------
  // Stage 3: magnitude |g| * 65536 / 12240 by reciprocal multiply
  // --------------------------------------------------------------------------
  logic [ABS_W-1:0]    abs3_r;
  logic                up3_r, end3_r;
  logic [RGBA_W-1:0]   col3_r;
  logic [RECIP_PW-1:0] recip3;

  always_ff @(posedge clk) begin
    if (ld3) begin
      abs3_r <= abs2;
      up3_r  <= grad2 > 0;
      col3_r <= col2_r;
      end3_r <= end2_r;
    end
  end

  assign recip3 = RECIP_PW'(abs3_r) * RECIP_PW'(RECIP_MUL);

  // --------------------------------------------------------------------------
  // Stage 4: per-channel products ch * (1 - v) and 255 * v
  // --------------------------------------------------------------------------
  logic [MAG_W-1:0]  mag4_r;
  logic              up4_r, end4_r;
  logic [RGBA_W-1:0] col4_r;
  logic [INV_W-1:0]  inv4;

  always_ff @(posedge clk) begin
    if (ld4) begin
      mag4_r <= recip3[RECIP_SHIFT +: MAG_W];
      up4_r  <= up3_r;
      col4_r <= col3_r;
      end4_r <= end3_r;
    end
  end

  assign inv4 = (INV_W'(1) << MAG_W) - INV_W'(mag4_r);

  // --------------------------------------------------------------------------
  // Stage 5: sum and truncate to eight bits
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] pr5_r, pg5_r, pb5_r, pw5_r;
  logic [PIX_W-1:0]  alpha5_r;
  logic              up5_r, end5_r;
  logic [PIX_W-1:0]  white5;

  always_ff @(posedge clk) begin
    if (ld5) begin
      pr5_r    <= PROD_W'(col4_r[0 +: PIX_W]) * PROD_W'(inv4);
      pg5_r    <= PROD_W'(col4_r[PIX_W +: PIX_W]) * PROD_W'(inv4);
      pb5_r    <= PROD_W'(col4_r[2*PIX_W +: PIX_W]) * PROD_W'(inv4);
      pw5_r    <= PROD_W'(mag4_r) * PROD_W'(8'hFF);
      alpha5_r <= col4_r[3*PIX_W +: PIX_W];
      up5_r    <= up4_r;
      end5_r   <= end4_r;
    end
  end

  assign white5 = up5_r ? pw5_r[MAG_W +: PIX_W] : '0;

  // --------------------------------------------------------------------------
  // Stage 6: output register
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] red6_r, green6_r, blue6_r, alpha6_r;
  logic             end6_r;

  always_ff @(posedge clk) begin
    if (ld6) begin
      red6_r   <= pr5_r[MAG_W +: PIX_W] + white5;
      green6_r <= pg5_r[MAG_W +: PIX_W] + white5;
      blue6_r  <= pb5_r[MAG_W +: PIX_W] + white5;
      alpha6_r <= alpha5_r;
      end6_r   <= end5_r;
    end
  end

  // Valid bits travel with the data; rows above the emboss window drop out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (ld1) begin
        v1_r <= accept && !ign;
      end
      if (ld2) begin
        v2_r <= v1_r && f1_r.emit;
      end
      if (ld3) begin
        v3_r <= v2_r;
      end
      if (ld4) begin
        v4_r <= v3_r;
      end
      if (ld5) begin
        v5_r <= v4_r;
      end
      if (ld6) begin
        v6_r <= v5_r;
      end
    end
  end

  assign out_chan.valid     = v6_r;
  assign out_chan.red_out   = red6_r;
  assign out_chan.green_out = green6_r;
  assign out_chan.blue_out  = blue6_r;
  assign out_chan.alpha_out = alpha6_r;
  assign out_chan.frame_end = end6_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !ign && flags0.last && !cfg_we) |=> (col_r == '0) && (row_r == '0))
    else $error("stream position not restarted after last pixel");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    WID_W'(col_r) < eff_w_r)
    else $error("column position beyond image width");

  a_drop_idle_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ign) |=> !v1_r)
    else $error("idle flush entered the pipeline");

endmodule
